// ===== hw/rtl/tccf_pkg.sv =====
// ============================================================================
// tccf_pkg
// Shared types, constants and helper functions of the tilt-compensated
// compass fusion core.
// ============================================================================
`default_nettype none

package tccf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 24;

    // CORDIC datapath widths
    localparam int XY_W = 58;
    localparam int Z_W  = 37;
    // shared multiplier operand and product widths
    localparam int MA_W = 37;
    localparam int MB_W = 30;
    localparam int P_W  = MA_W + MB_W;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 37'sd3373259426;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 37'sd6746518852;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 37'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 58'sd652032874;
    localparam logic signed [XY_W-1:0] NORM_LIMIT  = 58'sd1125899906842624;

    localparam logic signed [MB_W-1:0] CDEG_PER_RAD_Q16   = 30'sd375493621;
    localparam logic signed [MB_W-1:0] GYRO_MS_TO_Q30_Q16 = 30'sd76760392;
    localparam logic signed [P_W-1:0]  DELTA_LIMIT        = 67'sd33554432;
    localparam logic signed [P_W-1:0]  TILT_CDEG_LIMIT    = 67'sd45837;
    localparam logic signed [P_W-1:0]  YAW_CDEG_LIMIT     = 67'sd18000;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    // square root: 52-bit radicand, 26 result bits
    localparam int SQ_W    = 52;
    localparam int ROOT_W  = 26;

    // APB register indexes
    localparam logic REG_GYRO_WEIGHT = 1'b0;
    localparam logic REG_FIRST_INTVL = 1'b1;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cor_req;

    typedef enum logic [2:0] {
        C_IDLE,
        C_NORM,
        C_PRE,
        C_RED,
        C_ITER
    } t_cor_state;

    typedef enum logic [5:0] {
        S_IDLE,
        S_MW,
        S_SQ_A,
        S_SQ_C,
        S_SQ_E,
        S_SQRT_W,
        S_AR_W,
        S_GP_A,
        S_GP_C,
        S_GP_E,
        S_GR_C,
        S_GR_E,
        S_AP_W,
        S_BP_A,
        S_BP_B,
        S_BP_C,
        S_BR_A,
        S_BR_B,
        S_BR_C,
        S_SR,
        S_SR_W,
        S_SP_W,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_YS,
        S_YW,
        S_Y1,
        S_D1,
        S_D2,
        S_D3,
        S_OUT
    } t_state;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // v / 2^n, rounded to nearest with ties away from zero (n > 0)
    function automatic logic signed [P_W-1:0] rnd_shr(input logic signed [P_W-1:0] v,
                                                      input int unsigned n);
        logic [P_W-1:0] m;
        logic [P_W-1:0] half;
        m    = (v < 0) ? P_W'(-v) : P_W'(v);
        half = P_W'(1) << (n - 1);
        m    = (m + half) >> n;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [P_W-1:0] clamp_sym(input logic signed [P_W-1:0] v,
                                                        input logic signed [P_W-1:0] lim);
        logic signed [P_W-1:0] r;
        if (v < -lim) begin
            r = -lim;
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tilt_compensated_compass_fusion_core.sv =====
// ============================================================================
// tilt_compensated_compass_fusion_core
// Complementary-filter roll/pitch and tilt-compensated heading per IMU item.
// ============================================================================
// The time per item grows with CORDIC_STEPS and with the normalizing shifts
//   of the three atan2 passes (one bit per cycle).
// Throughput: one item at a time; s_axis_tready is high only while idle.
//   The CORDIC unit and the shared 37x30 multiplier set the pace.
// Reset (synchronous, active low): filtered angles and last timestamp go to
//   zero, gyro_weight to 205, first_interval_ms to 50, output empty.
`default_nettype none

module tilt_compensated_compass_fusion_core #(
    parameter int CORDIC_STEPS    = tccf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tccf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input items
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, mag_x, mag_y, mag_z (16 each),
    // timestamp_ms (32)
    input  wire logic [159:0]  s_axis_tdata,
    // result items
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // pitch_cdeg (17), roll_cdeg (17), yaw_cdeg (16), zero pad (6)
    output logic [55:0]        m_axis_tdata,
    // configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SW     = ANGLE_FRAC_BITS + 4;     // stored angle width
    localparam int Q_SH   = 30 - ANGLE_FRAC_BITS;     // state to Q30 shift
    localparam int BL_SH  = 8 + 30 - ANGLE_FRAC_BITS; // blend rounding shift
    localparam logic signed [tccf_pkg::P_W-1:0] ANGLE_LIMIT =
        (tccf_pkg::P_W'(8) <<< ANGLE_FRAC_BITS) - tccf_pkg::P_W'(1);

    localparam int MA_W = tccf_pkg::MA_W;
    localparam int MB_W = tccf_pkg::MB_W;
    localparam int P_W  = tccf_pkg::P_W;
    localparam int XY_W = tccf_pkg::XY_W;
    localparam int Z_W  = tccf_pkg::Z_W;

    // ---------------------------------------------------------------- config
    logic [8:0] r_gyro_weight;
    logic [9:0] r_first_intvl;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight <= 9'd205;
            r_first_intvl <= 10'd50;
        end else if (cfg_wr) begin
            case (paddr[2])
                tccf_pkg::REG_GYRO_WEIGHT: r_gyro_weight <= pwdata[8:0];
                tccf_pkg::REG_FIRST_INTVL: r_first_intvl <= pwdata[9:0];
                default: r_gyro_weight <= r_gyro_weight;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tccf_pkg::REG_GYRO_WEIGHT: prdata = {23'd0, r_gyro_weight};
            tccf_pkg::REG_FIRST_INTVL: prdata = {22'd0, r_first_intvl};
            default:                   prdata = '0;
        endcase
    end

    // weight above one acts as one
    logic [8:0] w_c;
    logic [8:0] w_inv;
    assign w_c   = (r_gyro_weight > tccf_pkg::WEIGHT_ONE) ? tccf_pkg::WEIGHT_ONE
                                                          : r_gyro_weight;
    assign w_inv = tccf_pkg::WEIGHT_ONE - w_c;

    // ---------------------------------------------------------------- state
    tccf_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic in_acc;
    assign s_axis_tready = (r_state == tccf_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // item fields
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_mx, r_my, r_mz;
    logic [31:0]        r_dt;
    logic [31:0]        r_last;

    // filter state
    logic signed [SW-1:0] r_pitch, r_roll;

    // intermediates
    logic signed [P_W-1:0]  r_t0;
    logic [tccf_pkg::ROOT_W-1:0] r_hyp;
    logic signed [Z_W-1:0]  r_acc_r, r_acc_p, r_inc_p, r_inc_r, r_yaw;
    logic signed [25:0]     r_sr, r_cr, r_sp, r_cp;
    logic signed [44:0]     r_by;
    logic signed [43:0]     r_bz;
    logic signed [XY_W-1:0] r_bx;
    logic signed [16:0]     r_pc, r_rc;
    logic signed [15:0]     r_yc;

    // shared multiplier
    logic signed [MA_W-1:0] r_ma;
    logic signed [MB_W-1:0] r_mb;
    logic signed [P_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    // output register
    logic        r_out_valid;
    logic [55:0] r_out_data;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------- units
    tccf_pkg::t_cor_req     cor_req;
    logic signed [XY_W-1:0] cor_xi, cor_yi, cor_xo, cor_yo;
    logic signed [Z_W-1:0]  cor_zi, cor_zo;
    logic                   cor_busy;

    tccf_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cor_req),
        .i_x    (cor_xi),
        .i_y    (cor_yi),
        .i_z    (cor_zi),
        .o_busy (cor_busy),
        .o_x    (cor_xo),
        .o_y    (cor_yo),
        .o_z    (cor_zo)
    );

    logic                         sq_start;
    logic                         sq_busy;
    logic [tccf_pkg::SQ_W-1:0]    sq_in;
    logic [tccf_pkg::ROOT_W-1:0]  sq_root;

    // radicand (ay^2 + az^2) << 20
    assign sq_in = tccf_pkg::SQ_W'(r_t0 + r_prod) << 20;

    tccf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_value(sq_in),
        .o_busy (sq_busy),
        .o_root (sq_root)
    );

    // Q30 views of the stored angles
    logic signed [MA_W-1:0] pitch_q30, roll_q30;
    assign pitch_q30 = MA_W'(r_pitch) <<< Q_SH;
    assign roll_q30  = MA_W'(r_roll) <<< Q_SH;

    // gyro delta clamp, blend result
    logic signed [P_W-1:0] d_clamp, blend_v;
    assign d_clamp = tccf_pkg::clamp_sym(r_prod, tccf_pkg::DELTA_LIMIT);
    assign blend_v = tccf_pkg::clamp_sym(tccf_pkg::rnd_shr(r_t0 + r_prod, BL_SH),
                                         ANGLE_LIMIT);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccf_pkg::S_IDLE;
            r_ret   <= tccf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        cor_req  = '0;
        sq_start = 1'b0;
        cor_xi   = MA_W'(0);
        cor_yi   = '0;
        cor_zi   = '0;
        case (r_state)
            tccf_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = tccf_pkg::S_SQ_A;
                end
            end
            // wait for the registered product, then resume
            tccf_pkg::S_MW: n_state = r_ret;
            tccf_pkg::S_SQ_A: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_SQ_C;
            end
            tccf_pkg::S_SQ_C: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_SQ_E;
            end
            tccf_pkg::S_SQ_E: begin
                sq_start = 1'b1;
                n_state  = tccf_pkg::S_SQRT_W;
            end
            tccf_pkg::S_SQRT_W: begin
                // accelerometer roll = atan2(ay, az)
                cor_yi = XY_W'(r_ay);
                cor_xi = XY_W'(r_az);
                if (!sq_busy) begin
                    cor_req.start = 1'b1;
                    n_state       = tccf_pkg::S_AR_W;
                end
            end
            tccf_pkg::S_AR_W: begin
                // accelerometer pitch = atan2(-ax * 1024, hypot)
                cor_yi = -(XY_W'(r_ax) <<< 10);
                cor_xi = XY_W'(r_hyp);
                if (!cor_busy) begin
                    cor_req.start = 1'b1;
                    n_state       = tccf_pkg::S_GP_A;
                end
            end
            tccf_pkg::S_GP_A: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_GP_C;
            end
            tccf_pkg::S_GP_C: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_GP_E;
            end
            tccf_pkg::S_GP_E: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_GR_C;
            end
            tccf_pkg::S_GR_C: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_GR_E;
            end
            tccf_pkg::S_GR_E: n_state = tccf_pkg::S_AP_W;
            tccf_pkg::S_AP_W: begin
                if (!cor_busy) begin
                    n_state = tccf_pkg::S_BP_A;
                end
            end
            tccf_pkg::S_BP_A: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_BP_B;
            end
            tccf_pkg::S_BP_B: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_BP_C;
            end
            tccf_pkg::S_BP_C: n_state = tccf_pkg::S_BR_A;
            tccf_pkg::S_BR_A: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_BR_B;
            end
            tccf_pkg::S_BR_B: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_BR_C;
            end
            tccf_pkg::S_BR_C: n_state = tccf_pkg::S_SR;
            tccf_pkg::S_SR: begin
                cor_zi         = roll_q30;
                cor_req.start  = 1'b1;
                cor_req.rotate = 1'b1;
                n_state        = tccf_pkg::S_SR_W;
            end
            tccf_pkg::S_SR_W: begin
                cor_zi = pitch_q30;
                if (!cor_busy) begin
                    cor_req.start  = 1'b1;
                    cor_req.rotate = 1'b1;
                    n_state        = tccf_pkg::S_SP_W;
                end
            end
            tccf_pkg::S_SP_W: begin
                if (!cor_busy) begin
                    n_state = tccf_pkg::S_M1;
                end
            end
            tccf_pkg::S_M1: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M2;
            end
            tccf_pkg::S_M2: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M3;
            end
            tccf_pkg::S_M3: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M4;
            end
            tccf_pkg::S_M4: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M5;
            end
            tccf_pkg::S_M5: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M6;
            end
            tccf_pkg::S_M6: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_M7;
            end
            tccf_pkg::S_M7: n_state = tccf_pkg::S_YS;
            tccf_pkg::S_YS: begin
                // heading = atan2(by * 4096, bx)
                cor_yi        = XY_W'(r_by) <<< 12;
                cor_xi        = r_bx;
                cor_req.start = 1'b1;
                n_state       = tccf_pkg::S_YW;
            end
            tccf_pkg::S_YW: begin
                if (!cor_busy) begin
                    n_state = tccf_pkg::S_Y1;
                end
            end
            tccf_pkg::S_Y1: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_D1;
            end
            tccf_pkg::S_D1: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_D2;
            end
            tccf_pkg::S_D2: begin
                n_state = tccf_pkg::S_MW;
                n_ret   = tccf_pkg::S_D3;
            end
            tccf_pkg::S_D3: n_state = tccf_pkg::S_OUT;
            tccf_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_state = tccf_pkg::S_IDLE;
                end
            end
            default: n_state = tccf_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tccf_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_ax <= s_axis_tdata[15:0];
                    r_ay <= s_axis_tdata[31:16];
                    r_az <= s_axis_tdata[47:32];
                    r_gx <= s_axis_tdata[63:48];
                    r_gy <= s_axis_tdata[79:64];
                    r_mx <= s_axis_tdata[95:80];
                    r_my <= s_axis_tdata[111:96];
                    r_mz <= s_axis_tdata[127:112];
                    // last stamp zero (as after reset): use the configured first interval
                    r_dt <= (r_last == 32'd0) ? 32'(r_first_intvl)
                                              : s_axis_tdata[159:128] - r_last;
                end
            end
            tccf_pkg::S_SQ_A: begin
                r_ma <= MA_W'(r_ay);
                r_mb <= MB_W'(r_ay);
            end
            tccf_pkg::S_SQ_C: begin
                r_t0 <= r_prod;
                r_ma <= MA_W'(r_az);
                r_mb <= MB_W'(r_az);
            end
            tccf_pkg::S_SQRT_W: begin
                if (!sq_busy) begin
                    r_hyp <= sq_root;
                end
            end
            tccf_pkg::S_AR_W: begin
                if (!cor_busy) begin
                    r_acc_r <= cor_zo;
                end
            end
            tccf_pkg::S_GP_A: begin
                r_ma <= MA_W'(r_dt);
                r_mb <= MB_W'(r_gy);
            end
            tccf_pkg::S_GP_C: begin
                r_ma <= MA_W'(d_clamp);
                r_mb <= tccf_pkg::GYRO_MS_TO_Q30_Q16;
            end
            tccf_pkg::S_GP_E: begin
                r_inc_p <= Z_W'(tccf_pkg::rnd_shr(r_prod, 16));
                r_ma    <= MA_W'(r_dt);
                r_mb    <= MB_W'(r_gx);
            end
            tccf_pkg::S_GR_C: begin
                r_ma <= MA_W'(d_clamp);
                r_mb <= tccf_pkg::GYRO_MS_TO_Q30_Q16;
            end
            tccf_pkg::S_GR_E: begin
                r_inc_r <= Z_W'(tccf_pkg::rnd_shr(r_prod, 16));
            end
            tccf_pkg::S_AP_W: begin
                if (!cor_busy) begin
                    r_acc_p <= cor_zo;
                end
            end
            tccf_pkg::S_BP_A: begin
                r_ma <= pitch_q30 + MA_W'(r_inc_p);
                r_mb <= MB_W'(w_c);
            end
            tccf_pkg::S_BP_B: begin
                r_t0 <= r_prod;
                r_ma <= MA_W'(r_acc_p);
                r_mb <= MB_W'(w_inv);
            end
            tccf_pkg::S_BR_A: begin
                r_ma <= roll_q30 + MA_W'(r_inc_r);
                r_mb <= MB_W'(w_c);
            end
            tccf_pkg::S_BR_B: begin
                r_t0 <= r_prod;
                r_ma <= MA_W'(r_acc_r);
                r_mb <= MB_W'(w_inv);
            end
            tccf_pkg::S_SR_W: begin
                if (!cor_busy) begin
                    r_sr <= 26'(tccf_pkg::rnd_shr(P_W'(cor_yo), 6));
                    r_cr <= 26'(tccf_pkg::rnd_shr(P_W'(cor_xo), 6));
                end
            end
            tccf_pkg::S_SP_W: begin
                if (!cor_busy) begin
                    r_sp <= 26'(tccf_pkg::rnd_shr(P_W'(cor_yo), 6));
                    r_cp <= 26'(tccf_pkg::rnd_shr(P_W'(cor_xo), 6));
                end
            end
            tccf_pkg::S_M1: begin
                r_ma <= MA_W'(r_mz);
                r_mb <= MB_W'(r_sr);
            end
            tccf_pkg::S_M2: begin
                r_t0 <= r_prod;
                r_ma <= MA_W'(r_my);
                r_mb <= MB_W'(r_cr);
            end
            tccf_pkg::S_M3: begin
                r_by <= 45'(r_t0 - r_prod);
                r_ma <= MA_W'(r_my);
                r_mb <= MB_W'(r_sr);
            end
            tccf_pkg::S_M4: begin
                r_t0 <= r_prod;
                r_ma <= MA_W'(r_mz);
                r_mb <= MB_W'(r_cr);
            end
            tccf_pkg::S_M5: begin
                r_bz <= 44'(r_t0 + r_prod);
                r_ma <= MA_W'(r_mx);
                r_mb <= MB_W'(r_cp);
            end
            tccf_pkg::S_M6: begin
                r_t0 <= r_prod <<< 12;
                r_ma <= MA_W'(tccf_pkg::rnd_shr(P_W'(r_bz), 12));
                r_mb <= MB_W'(r_sp);
            end
            tccf_pkg::S_M7: begin
                r_bx <= XY_W'(r_t0 + r_prod);
            end
            tccf_pkg::S_YW: begin
                if (!cor_busy) begin
                    r_yaw <= cor_zo;
                end
            end
            tccf_pkg::S_Y1: begin
                r_ma <= pitch_q30;
                r_mb <= tccf_pkg::CDEG_PER_RAD_Q16;
            end
            tccf_pkg::S_D1: begin
                r_pc <= 17'(tccf_pkg::clamp_sym(tccf_pkg::rnd_shr(r_prod, 46),
                                                tccf_pkg::TILT_CDEG_LIMIT));
                r_ma <= roll_q30;
            end
            tccf_pkg::S_D2: begin
                r_rc <= 17'(tccf_pkg::clamp_sym(tccf_pkg::rnd_shr(r_prod, 46),
                                                tccf_pkg::TILT_CDEG_LIMIT));
                r_ma <= MA_W'(r_yaw);
            end
            tccf_pkg::S_D3: begin
                r_yc <= 16'(tccf_pkg::clamp_sym(tccf_pkg::rnd_shr(r_prod, 46),
                                                tccf_pkg::YAW_CDEG_LIMIT));
            end
            default: begin
                r_t0 <= r_t0;
            end
        endcase
    end

    // filter state, timestamp and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch     <= '0;
            r_roll      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_last <= s_axis_tdata[159:128];
            end
            if (r_state == tccf_pkg::S_BP_C) begin
                r_pitch <= SW'(blend_v);
            end
            if (r_state == tccf_pkg::S_BR_C) begin
                r_roll <= SW'(blend_v);
            end
            if (r_state == tccf_pkg::S_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tccf_pkg::S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {6'd0, r_yc, r_rc, r_pc};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tccf_isqrt.sv =====
// ============================================================================
// tccf_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ============================================================================
`default_nettype none

module tccf_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tccf_pkg::SQ_W-1:0]     i_value,
    output logic                               o_busy,
    output logic [tccf_pkg::ROOT_W-1:0]        o_root
);

    logic                       r_busy;
    logic [tccf_pkg::SQ_W-1:0]  r_v;
    logic [tccf_pkg::SQ_W-1:0]  r_r;
    logic [4:0]                 r_k;
    logic [tccf_pkg::SQ_W-1:0]  bit_w;
    logic [tccf_pkg::SQ_W-1:0]  cand;

    assign bit_w = tccf_pkg::SQ_W'(1) << {r_k, 1'b0};
    assign cand  = r_r + bit_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_k == 5'd0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= '0;
            r_k <= 5'(tccf_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (r_v >= cand) begin
                r_v <= r_v - cand;
                r_r <= (r_r >> 1) + bit_w;
            end else begin
                r_r <= r_r >> 1;
            end
            r_k <= r_k - 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[tccf_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/tccf_cordic.sv =====
// ============================================================================
// tccf_cordic
// Shared CORDIC unit: vectoring (atan2) and rotation (sine, cosine).
// ============================================================================
`default_nettype none

module tccf_cordic #(
    parameter int CORDIC_STEPS = tccf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tccf_pkg::t_cor_req                  i_req,
    input  wire logic signed [tccf_pkg::XY_W-1:0]    i_x,
    input  wire logic signed [tccf_pkg::XY_W-1:0]    i_y,
    input  wire logic signed [tccf_pkg::Z_W-1:0]     i_z,
    output logic                                     o_busy,
    output logic signed [tccf_pkg::XY_W-1:0]         o_x,
    output logic signed [tccf_pkg::XY_W-1:0]         o_y,
    output logic signed [tccf_pkg::Z_W-1:0]          o_z
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

    tccf_pkg::t_cor_state r_state, n_state;

    logic signed [tccf_pkg::XY_W-1:0] r_x, r_y, sh_x, sh_y, nx, ny;
    logic signed [tccf_pkg::Z_W-1:0]  r_z, nz, ang;
    logic [IW-1:0]                    r_i;
    logic                             r_neg;
    logic                             r_rot;
    logic                             in_norm;

    assign sh_x = r_x >>> r_i;
    assign sh_y = r_y >>> r_i;
    assign ang  = tccf_pkg::Z_W'(tccf_pkg::atan_entry(5'(r_i)));
    assign in_norm = (r_x > -tccf_pkg::NORM_LIMIT) && (r_x < tccf_pkg::NORM_LIMIT)
                  && (r_y > -tccf_pkg::NORM_LIMIT) && (r_y < tccf_pkg::NORM_LIMIT);

    // one micro-rotation
    always_comb begin
        if (r_rot ? (r_z >= 0) : (r_y <= 0)) begin
            nx = r_x - sh_y;
            ny = r_y + sh_x;
            nz = r_z - ang;
        end else begin
            nx = r_x + sh_y;
            ny = r_y - sh_x;
            nz = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccf_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tccf_pkg::C_IDLE: begin
                if (i_req.start) begin
                    if (i_req.rotate) begin
                        n_state = tccf_pkg::C_RED;
                    end else if (i_x != 0 || i_y != 0) begin
                        n_state = tccf_pkg::C_NORM;
                    end
                end
            end
            tccf_pkg::C_NORM: begin
                if (!in_norm) begin
                    n_state = tccf_pkg::C_PRE;
                end
            end
            tccf_pkg::C_PRE: n_state = tccf_pkg::C_ITER;
            tccf_pkg::C_RED: begin
                if (r_z <= tccf_pkg::PI_Q30 && r_z >= -tccf_pkg::PI_Q30) begin
                    n_state = tccf_pkg::C_ITER;
                end
            end
            tccf_pkg::C_ITER: begin
                if (r_i == LAST) begin
                    n_state = tccf_pkg::C_IDLE;
                end
            end
            default: n_state = tccf_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tccf_pkg::C_IDLE: begin
                if (i_req.start) begin
                    r_rot <= i_req.rotate;
                    r_neg <= 1'b0;
                    r_i   <= '0;
                    if (i_req.rotate) begin
                        r_x <= tccf_pkg::GAIN_Q30;
                        r_y <= '0;
                        r_z <= i_z;
                    end else begin
                        r_x <= i_x;
                        r_y <= i_y;
                        r_z <= '0;
                    end
                end
            end
            tccf_pkg::C_NORM: begin
                if (in_norm) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            tccf_pkg::C_PRE: begin
                // move a left-half vector into the right half
                if (r_x < 0) begin
                    if (r_y >= 0) begin
                        r_x <= r_y;
                        r_y <= -r_x;
                        r_z <= tccf_pkg::HALF_PI_Q30;
                    end else begin
                        r_x <= -r_y;
                        r_y <= r_x;
                        r_z <= -tccf_pkg::HALF_PI_Q30;
                    end
                end
            end
            tccf_pkg::C_RED: begin
                if (r_z > tccf_pkg::PI_Q30) begin
                    r_z <= r_z - tccf_pkg::TWO_PI_Q30;
                end else if (r_z < -tccf_pkg::PI_Q30) begin
                    r_z <= r_z + tccf_pkg::TWO_PI_Q30;
                end else if (r_z > tccf_pkg::HALF_PI_Q30) begin
                    r_z   <= r_z - tccf_pkg::PI_Q30;
                    r_neg <= 1'b1;
                end else if (r_z < -tccf_pkg::HALF_PI_Q30) begin
                    r_z   <= r_z + tccf_pkg::PI_Q30;
                    r_neg <= 1'b1;
                end
            end
            tccf_pkg::C_ITER: begin
                r_i <= r_i + IW'(1);
                r_z <= nz;
                if (r_i == LAST && r_rot && r_neg) begin
                    r_x <= -nx;
                    r_y <= -ny;
                end else begin
                    r_x <= nx;
                    r_y <= ny;
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_busy = (r_state != tccf_pkg::C_IDLE);
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

// ===== dv/tilt_compensated_compass_fusion_core_tb.sv =====
// ============================================================================
// tilt_compensated_compass_fusion_core_tb
// Self-checking bench for the compass fusion core: IMU items go in on the
// slave stream, a bit-exact predictor of the filter and heading math builds
// the expected pitch, roll and yaw, and every result item is compared with
// the oldest expectation. Runs several weight/interval settings and several
// idle and stall patterns on both stream sides.
// ============================================================================
`default_nettype none

module tilt_compensated_compass_fusion_core_tb;
    import tccf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point constants of the fusion math
    localparam longint PI_Q      = 64'sd3373259426;
    localparam longint TWO_PI_Q  = 64'sd6746518852;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint CORDIC_K  = 64'sd652032874;
    localparam longint CDEG_MUL  = 64'sd375493621;
    localparam longint GYRO_MUL  = 64'sd76760392;
    localparam longint RATE_CLIP = 64'sd33554432;
    localparam longint NORM_TOP  = 64'sd1 << 50;
    localparam int     FRAC_BITS = 24;
    localparam longint ANG_MAX   = (64'sd8 << FRAC_BITS) - 1;
    localparam longint STATE_UP  = 64'sd1 << (30 - FRAC_BITS);
    localparam int     N_ROT     = 16;
    localparam longint ARCTAN_Q30 [0:15] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, mx, my, mz;
        logic [31:0]        ts;
    } imu_sample_t;

    typedef struct {
        logic [16:0] pitch;
        logic [16:0] roll;
        logic [15:0] yaw;
    } attitude_t;

    // ------------------------------------------------------------------------
    // Attitude predictor and pending-result store
    // ------------------------------------------------------------------------
    class attitude_scoreboard;
        attitude_t   pending[$];
        int          errors;
        int unsigned weight;
        int unsigned first_dt;
        longint      pitch_st, roll_st;
        logic [31:0] prev_ts;

        function new();
            errors   = 0;
            weight   = 205;
            first_dt = 50;
            pitch_st = 0;
            roll_st  = 0;
            prev_ts  = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_GYRO_WEIGHT) begin
                weight = val[8:0];
            end else begin
                first_dt = val[9:0];
            end
        endfunction

        // divide by 2^n, round to nearest, ties away from zero
        function longint rshift_rnd(longint v, int n);
            longint unsigned m;
            if (n <= 0) return v;
            m = (v < 0) ? longint'(-v) : v;
            m = (m + (64'd1 << (n - 1))) >> n;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint clip(longint v, longint lim);
            return (v < -lim) ? -lim : ((v > lim) ? lim : v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint vec_angle(longint y, longint x);
            longint z, t, nx, ny;
            z = 0;
            if (x == 0 && y == 0) return 0;
            while (x > -NORM_TOP && x < NORM_TOP && y > -NORM_TOP && y < NORM_TOP) begin
                x *= 2;
                y *= 2;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = HALF_PI_Q;
                end else begin
                    x = -y; y = t; z = -HALF_PI_Q;
                end
            end
            for (int i = 0; i < N_ROT; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN_Q30[i];
                end else begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN_Q30[i];
                end
                x = nx;
                y = ny;
            end
            return z;
        endfunction

        function void rotate(longint th, output longint s, output longint c);
            longint x, y, nx, ny;
            bit     flip;
            x = CORDIC_K;
            y = 0;
            flip = 0;
            while (th > PI_Q) th -= TWO_PI_Q;
            while (th < -PI_Q) th += TWO_PI_Q;
            if (th > HALF_PI_Q) begin
                th -= PI_Q; flip = 1;
            end else if (th < -HALF_PI_Q) begin
                th += PI_Q; flip = 1;
            end
            for (int i = 0; i < N_ROT; i++) begin
                if (th >= 0) begin
                    nx = x - (y >>> i); ny = y + (x >>> i); th -= ARCTAN_Q30[i];
                end else begin
                    nx = x + (y >>> i); ny = y - (x >>> i); th += ARCTAN_Q30[i];
                end
                x = nx;
                y = ny;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint gyro_step(longint rate, logic [31:0] dt);
            longint d;
            d = clip(rate * longint'({32'd0, dt}), RATE_CLIP);
            return rshift_rnd(d * GYRO_MUL, 16);
        endfunction

        function longint fuse(longint st, longint inc, longint acc);
            longint w, v;
            w = (weight > 256) ? 256 : weight;
            v = w * (st * STATE_UP + inc) + (256 - w) * acc;
            return clip(rshift_rnd(v, 8 + 30 - FRAC_BITS), ANG_MAX);
        endfunction

        function longint centideg(longint q30, longint lim);
            return clip(rshift_rnd(q30 * CDEG_MUL, 46), lim);
        endfunction

        // predict the result of one accepted IMU item
        function void note_sample(imu_sample_t s);
            longint ax, ay, az, mx, my, mz, acc_r, acc_p, hyp;
            longint sr, cr, sp, cp, by, bz, bx, yaw;
            logic [31:0] dt;
            attitude_t e;
            ax = s.ax; ay = s.ay; az = s.az;
            mx = s.mx; my = s.my; mz = s.mz;
            acc_r = vec_angle(ay, az);
            hyp   = int_sqrt(longint'(ay * ay + az * az) << 20);
            acc_p = vec_angle(-ax * 1024, hyp);
            dt = (prev_ts == 0) ? first_dt : s.ts - prev_ts;
            prev_ts = s.ts;
            pitch_st = fuse(pitch_st, gyro_step(s.gy, dt), acc_p);
            roll_st  = fuse(roll_st, gyro_step(s.gx, dt), acc_r);
            rotate(roll_st * STATE_UP, sr, cr);
            rotate(pitch_st * STATE_UP, sp, cp);
            sr = rshift_rnd(sr, 6); cr = rshift_rnd(cr, 6);
            sp = rshift_rnd(sp, 6); cp = rshift_rnd(cp, 6);
            by = mz * sr - my * cr;
            bz = my * sr + mz * cr;
            bx = mx * cp * 4096 + rshift_rnd(bz, 12) * sp;
            yaw = vec_angle(by * 4096, bx);
            e.pitch = 17'(centideg(pitch_st * STATE_UP, 45837));
            e.roll  = 17'(centideg(roll_st * STATE_UP, 45837));
            e.yaw   = 16'(centideg(yaw, 18000));
            pending.push_back(e);
        endfunction

        function void check_result(logic [55:0] d);
            attitude_t e;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[16:0] !== e.pitch) begin
                $error("pitch_cdeg: expected %0d, got %0d", $signed(e.pitch), $signed(d[16:0]));
                errors++;
            end
            if (d[33:17] !== e.roll) begin
                $error("roll_cdeg: expected %0d, got %0d", $signed(e.roll), $signed(d[33:17]));
                errors++;
            end
            if (d[49:34] !== e.yaw) begin
                $error("yaw_cdeg: expected %0d, got %0d", $signed(e.yaw), $signed(d[49:34]));
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    attitude_scoreboard sb = new();
    int          src_idle_pct = 0;   // sender gap chance per cycle, percent
    int          snk_stall_pct = 0;  // receiver stall chance per cycle, percent
    int          snk_hold = 0;       // long receiver hold-off, counted below
    logic [31:0] ts_run = 0;         // running timestamp of the random stream

    always #5 i_clk = ~i_clk;

    tilt_compensated_compass_fusion_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Receiver: check every accepted result, then pick ready for next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if (snk_hold > 0) begin
            snk_hold <= snk_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Timeout: far above the slowest legal run (1314 items).
    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Setup then access cycle; the register takes the value on the access edge.
    task automatic cfg_write(logic idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Offer one item; valid stays high afterwards so back-to-back items
    // need no second assignment in the same step.
    task automatic send_sample(imu_sample_t s);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.ts, s.mz, s.my, s.mx, s.gy, s.gx, s.az, s.ay, s.ax};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(s);
    endtask

    // Drop valid and wait until every expected result is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Mostly uniform, sometimes a field extreme or zero.
    function automatic logic signed [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy,
                                       int mx, int my, int mz, logic [31:0] ts);
        imu_sample_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy);
        s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz);
        s.ts = ts;
        return s;
    endfunction

    // Well-formed stream: advancing stamps, moderate rates; sometimes noise,
    // stamp jumps, a zero stamp or wraparound.
    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            s.ax = 16'($signed($urandom_range(8000)) - 4000);
            s.ay = 16'($signed($urandom_range(8000)) - 4000);
            s.az = 16'($signed($urandom_range(20000)) - 4000);
            s.gx = 16'($signed($urandom_range(4000)) - 2000);
            s.gy = 16'($signed($urandom_range(4000)) - 2000);
            ts_run += $urandom_range(1, 120);
        end else begin
            s.ax = pick16(); s.ay = pick16(); s.az = pick16();
            s.gx = pick16(); s.gy = pick16();
            case ($urandom_range(3))
                0: ts_run = $urandom;
                1: ts_run = 0;
                2: ts_run = 32'hFFFF_FFFF - $urandom_range(200);
                default: ts_run += $urandom_range(1, 100000);
            endcase
        end
        s.mx = pick16(); s.my = pick16(); s.mz = pick16();
        s.ts = ts_run;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        imu_sample_t dir[$];
        int w_set[5]  = '{205, 0, 256, 511, 128};
        int f_set[5]  = '{50, 0, 1000, 1023, 1};
        int idle[5]   = '{0, 63, 0, 12, 0};
        int stall[5]  = '{0, 0, 63, 12, 0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vectors, vertical pitch, extremes, first interval,
        // zero stamp, wraparound, rate clamping and angle saturation.
        dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(1000, 0, 0, 0, 0, 100, 0, 0, 100));
        dir.push_back(mk(-1000, 0, 0, 0, 0, 0, 100, 0, 150));
        dir.push_back(mk(0, 0, 16384, 0, 0, 200, 0, 300, 0));
        dir.push_back(mk(0, 0, 16384, 16, -16, 200, 50, 300, 20));
        dir.push_back(mk(-32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, 32'h7FFF_FFFF));
        dir.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                         32'hFFFF_FFF0));
        dir.push_back(mk(0, 100, 0, 32767, 32767, 0, 0, 0, 32'h0000_0010));
        dir.push_back(mk(0, -100, 0, 32767, 32767, -5, 0, 0, 32'h0010_0000));
        dir.push_back(mk(0, 0, -100, -32768, -32768, 0, -5, 9, 32'hFFFF_FFFF));
        dir.push_back(mk(0, 0, 100, -32768, -32768, 0, 0, -5, 32'h8000_0000));
        dir.push_back(mk(500, 300, -16000, 0, 0, 0, 0, 0, 32'h8000_0032));
        dir.push_back(mk(0, 0, 0, 0, 0, -1, 0, 0, 32'h8000_0064));
        dir.push_back(mk(-1, 1, 1, 1, -1, 1, -1, 1, 32'h8000_0065));
        foreach (dir[i]) send_sample(dir[i]);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            // registers change only with the core idle
            if (ph > 0) begin
                cfg_write(REG_GYRO_WEIGHT, w_set[ph]);
                cfg_write(REG_FIRST_INTVL, f_set[ph]);
            end
            src_idle_pct  = idle[ph];
            snk_stall_pct = stall[ph];
            ts_run = 0;
            // first phase: hold the receiver off long enough to stall input
            if (ph == 0) snk_hold = 3000;
            for (int n = 0; n < 260; n++) begin
                send_sample(random_sample());
            end
            drain();
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
